>>> src/nnt_pkg.sv
// Package for the nearest node table: sizes, operation and status codes,
// and the controller state type. No dependencies.
package nnt_pkg;

  // Store depth and derived address and count widths
  localparam int MAX_NODES = 4096;
  localparam int AW        = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // Field widths
  localparam int CW      = 16;              // coordinate bits
  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int ST_W    = 2;
  localparam int STEP_W  = 15;
  localparam int D_W     = 2 * CW + 1;      // squared distance
  localparam int SQS_W   = 2 * STEP_W;      // squared step
  localparam int THR_W   = SQS_W - 2;       // quarter of squared step

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

  // Operation codes
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } nnt_state_t;

endpackage

>>> src/nnt_ifs.sv
// Request and result channel interfaces of the nearest node table.
// Depends on nnt_pkg for field widths.
interface nnt_in_if import nnt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;

  modport source (output valid, operation, pos_x, pos_y, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, output ready);
endinterface

interface nnt_out_if import nnt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] node_index;
  logic [ST_W-1:0]  status;

  modport source (output valid, node_index, status, input ready);
  modport sink   (input valid, node_index, status, output ready);
endinterface

>>> src/nearest_node_table.sv
// Nearest node table: a node position memory with a linear nearest search.
// Depends on nnt_pkg and the channel interfaces in nnt_ifs.sv.
//
// One request is worked at a time; a new request is taken as soon as the
// previous one has left the controller, even while its result still waits
// in the output register. Insert, clear and a query on an empty store pass
// through the done state to the output register once that is free, and the
// controller is free again as the result is registered.
// A query reads one stored node per cycle through the single read port of
// the node memory; each read passes the difference, square and sum
// registers to the compare, and the result then goes through the done state.
// An early stop on a close node ends the scan sooner, at that node. A
// result that waits in the output register holds the next one in the
// controller until it is taken. The memory needs no clearing after reset.
module nearest_node_table import nnt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  nnt_in_if.sink              in_chan,
  nnt_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [STEP_W-1:0]   cfg_wdata
);

  // Node memory: {x, y} per entry
  logic [2*CW-1:0] node_mem [MAX_NODES];
  logic [2*CW-1:0] rd_data_r;

  // Control state
  nnt_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              have_r, have_nxt;
  logic [D_W-1:0]    best_d_r, best_d_nxt;
  logic [AW-1:0]     res_idx_r, res_idx_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AW-1:0]     out_idx_r, out_idx_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  // Configuration and derived early-stop threshold
  logic [STEP_W-1:0] step_r;
  logic [SQS_W-1:0]  step_sq_r;
  logic [THR_W-1:0]  thr_r;
  logic [SQS_W-1:0]  step_sq_rnd;

  // Query point
  logic [CW-1:0]     qx_r, qy_r;

  // Distance pipeline
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic [CW-1:0]     dx_r, dy_r;
  logic [2*CW-1:0]   sqx_r, sqy_r;
  logic [D_W-1:0]    sum_r;

  logic              in_fire, out_fire, mem_we, issue;
  logic              improve, stop;
  logic              store_full;
  logic [CW-1:0]     rd_x, rd_y, dx_abs, dy_abs;
  logic signed [CW:0] dx_s, dy_s;
  logic [CW:0]       dx_neg, dy_neg;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign out_fire            = out_valid_r && out_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.node_index = IDX_W'(out_idx_r);
  assign out_chan.status     = out_status_r;

  assign store_full = (count_r == CNT_W'(MAX_NODES));
  assign mem_we     = in_fire && (in_chan.operation == OP_INSERT) && !store_full;
  assign issue      = (state_r == ST_SCAN) && (scan_idx_r != count_r);

  // Node memory write on insert, registered read for the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[count_r[AW-1:0]] <= {in_chan.pos_x, in_chan.pos_y};
    end
    rd_data_r <= node_mem[scan_idx_r[AW-1:0]];
  end

  // Step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  // Threshold: ceil(step^2 / 4), so d2 < thr means 2*d < step
  assign step_sq_rnd = step_sq_r + SQS_W'(3);
  always_ff @(posedge clk) begin
    step_sq_r <= SQS_W'(step_r) * SQS_W'(step_r);
    thr_r     <= step_sq_rnd[SQS_W-1:2];
  end

  // Absolute coordinate differences
  assign rd_x   = rd_data_r[2*CW-1:CW];
  assign rd_y   = rd_data_r[CW-1:0];
  assign dx_s   = $signed({rd_x[CW-1], rd_x}) - $signed({qx_r[CW-1], qx_r});
  assign dy_s   = $signed({rd_y[CW-1], rd_y}) - $signed({qy_r[CW-1], qy_r});
  assign dx_neg = -dx_s;
  assign dy_neg = -dy_s;
  assign dx_abs = dx_s[CW] ? dx_neg[CW-1:0] : dx_s[CW-1:0];
  assign dy_abs = dy_s[CW] ? dy_neg[CW-1:0] : dy_s[CW-1:0];

  // Pipeline payload: difference, square, sum
  always_ff @(posedge clk) begin
    idx1_r <= scan_idx_r[AW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    dx_r   <= dx_abs;
    dy_r   <= dy_abs;
    sqx_r  <= (2*CW)'(dx_r) * (2*CW)'(dx_r);
    sqy_r  <= (2*CW)'(dy_r) * (2*CW)'(dy_r);
    sum_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // Compare stage
  assign improve = (state_r == ST_SCAN) && v4_r && (!have_r || (sum_r < best_d_r));
  assign stop    = improve && (sum_r < D_W'(thr_r));

  // Pipeline valids; drop in-flight reads on an early stop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue && !stop;
      v2_r <= v1_r && !stop;
      v3_r <= v2_r && !stop;
      v4_r <= v3_r && !stop;
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qx_r <= in_chan.pos_x;
      qy_r <= in_chan.pos_y;
    end
  end

  // Controller: next state and control registers
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    have_nxt       = have_r;
    best_d_nxt     = best_d_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_fire;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_idx_nxt    = '0;
          res_status_nxt = STAT_OK;
          have_nxt       = 1'b0;
          scan_idx_nxt   = '0;
          state_nxt      = ST_DONE;
          priority if (in_chan.operation == OP_QUERY) begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else if (in_chan.operation == OP_INSERT) begin
            if (store_full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              res_idx_nxt = count_r[AW-1:0];
              count_nxt   = count_r + CNT_W'(1);
            end
          end else if (in_chan.operation == OP_CLEAR) begin
            count_nxt = '0;
          end else begin
            res_idx_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        // Advance the read address
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        // Keep the first strictly closer node
        if (improve) begin
          have_nxt    = 1'b1;
          best_d_nxt  = sum_r;
          res_idx_nxt = idx4_r;
        end
        if (stop) begin
          state_nxt = ST_DONE;
        end else if (!issue && !v1_r && !v2_r && !v3_r && !v4_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    best_d_r     <= best_d_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // Node count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES))
    else $error("node count beyond store depth");

  // Scan address never runs past the node count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_idx_r <= count_r)
    else $error("scan address beyond node count");

  // Distance pipeline is empty whenever the controller is idle
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("distance pipeline busy while idle");

  // An accepted insert into a store with room grows it by one
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance node count");

  // An empty-store result carries index zero
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EMPTY) |-> out_idx_r == '0)
    else $error("empty query result with nonzero index");
`endif

endmodule
